// ----- design/ccpid_pkg.sv -----
// ccpid_pkg: shared types, widths, register indexes and constants for the
// CC/CV PID regulator. No dependencies; used by ccpid_state and the top level.
`timescale 1ns / 1ps

package ccpid_pkg;

  localparam int unsigned GAIN_SCALE_DEF = 100;
  localparam int unsigned DAC_MAX_DEF    = 65000;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 15;

  // full sum range is below 2**28 in magnitude
  localparam int unsigned SUM_W = 29;
  localparam int unsigned DIV_W = 28;

  localparam logic signed [15:0] MODE_EXIT_ERR = 16'sd100;
  localparam logic signed [15:0] BLEED_FLOOR   = 16'sd100;
  localparam logic signed [15:0] BLEED_STEP    = 16'sd50;

  localparam logic [14:0] TV_RST  = 15'd0;
  localparam logic [14:0] TC_RST  = 15'd0;
  localparam logic [7:0]  OFF_RST = 8'd95;
  localparam logic [9:0]  KP_RST  = 10'd20;
  localparam logic [9:0]  KI_RST  = 10'd15;
  localparam logic [9:0]  KD_RST  = 10'd10;
  localparam logic [14:0] WL_RST  = 15'd30000;
  localparam logic [14:0] OA_RST  = 15'd100;

  typedef enum logic [CFG_AW-1:0] {
    REG_TARGET_V  = 3'd0,
    REG_TARGET_I  = 3'd1,
    REG_OFFSET_G  = 3'd2,
    REG_PROP_G    = 3'd3,
    REG_INTEG_G   = 3'd4,
    REG_DERIV_G   = 3'd5,
    REG_WINDUP    = 3'd6,
    REG_OVERSHOOT = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] offset_gain;
    logic [9:0] prop_gain;
    logic [9:0] integ_gain;
    logic [9:0] deriv_gain;
  } gains_t;

  // operands of the selected loop for one tick
  typedef struct packed {
    logic               cc_mode;
    logic [14:0]        target_v;
    logic signed [15:0] err;
    logic signed [15:0] integ;
    logic signed [16:0] diff;
  } loop_op_t;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > 17'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -17'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ----- design/cc_cv_pid_regulator.sv -----
// cc_cv_pid_regulator: top level of the CC/CV PID regulator; loop state in
// ccpid_state, then a product / sum / reciprocal-divide / clamp pipeline.
// Depends on ccpid_pkg and ccpid_state.
//
//   channel  dir  handshake            payload
//   in_      in   tvalid/tready        tdata: measured_voltage, measured_current,
//                                             output_enabled
//   out_     out  tvalid/tready        tdata: dac_value, cc_mode
//   cfg_     in   we (no wait)         addr = register index, wdata
//
// One item per cycle sustained while out_tready stays high; out_tvalid follows the in transfer
// through five registers (operand, product, sum, reciprocal product, output).
// Loop state updates at the in transfer, so back-to-back ticks chain directly.
// Reset (rst_n low, synchronous) restores register defaults and zeroes state.
// Each stage holds when the one after it is full and stalled; bubbles collapse,
// so up to five items are held while out_tready is low.
`timescale 1ns / 1ps

module cc_cv_pid_regulator #(
  parameter int unsigned GAIN_SCALE = ccpid_pkg::GAIN_SCALE_DEF,
  parameter int unsigned DAC_MAX    = ccpid_pkg::DAC_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [31:0]                  in_tdata,   // [14:0] measured_voltage,
                                                   // [29:15] measured_current,
                                                   // [30] output_enabled, [31] 0
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [23:0]                  out_tdata,  // [15:0] dac_value, [16] cc_mode,
                                                   // [23:17] 0
  input  logic                         cfg_we,
  input  logic [ccpid_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [ccpid_pkg::CFG_DW-1:0] cfg_wdata
);

  localparam int unsigned SW   = ccpid_pkg::SUM_W;
  localparam int unsigned DW   = ccpid_pkg::DIV_W;
  localparam int unsigned LG   = $clog2(GAIN_SCALE);
  localparam int unsigned SHR  = DW + LG;
  localparam int unsigned MW   = DW + 1;
  localparam int unsigned QPW  = DW + MW;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SHR) + 64'(GAIN_SCALE) - 64'd1) / 64'(GAIN_SCALE);
  localparam logic [MW-1:0] RECIP   = RECIP_WIDE[MW-1:0];
  localparam logic [DW-1:0] DAC_LIM = DW'(DAC_MAX);

  logic take;
  ccpid_pkg::gains_t   gains;
  ccpid_pkg::loop_op_t op;

  logic en1, en2, en3, en4, en_out;
  logic v1_r, v2_r, v3_r, v4_r, out_v_r;

  ccpid_pkg::loop_op_t s1_r;
  logic               s2_mode_r, s3_mode_r, s4_mode_r;
  logic [22:0]        s2_ff_r, s2_ff_nxt;
  logic signed [26:0] s2_p_r, s2_p_nxt, s2_i_r, s2_i_nxt;
  logic signed [27:0] s2_d_r, s2_d_nxt;
  logic signed [SW-1:0] s3_sum_r, s3_sum_nxt;
  logic [QPW-1:0]     s4_qp_r, s4_qp_nxt;
  logic               s4_np_r, s4_np_nxt;
  logic [DW-1:0]      quot;
  logic [15:0]        dac_r, dac_nxt;
  logic               mode_out_r;

  assign en_out    = !out_v_r || out_tready;
  assign en4       = !v4_r || en_out;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;
  assign take      = in_tvalid && in_tready;

  ccpid_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .meas_v    (in_tdata[14:0]),
    .meas_i    (in_tdata[29:15]),
    .out_en    (in_tdata[30]),
    .gains     (gains),
    .op        (op)
  );

  always_comb begin
    s2_ff_nxt = 23'(gains.offset_gain) * 23'(s1_r.target_v);
    s2_p_nxt  = $signed({1'b0, gains.prop_gain}) * s1_r.err;
    s2_i_nxt  = $signed({1'b0, gains.integ_gain}) * s1_r.integ;
    s2_d_nxt  = $signed({1'b0, gains.deriv_gain}) * s1_r.diff;

    s3_sum_nxt = $signed({{(SW-23){1'b0}}, s2_ff_r})
               + {{(SW-27){s2_p_r[26]}}, s2_p_r}
               + {{(SW-27){s2_i_r[26]}}, s2_i_r}
               + {{(SW-28){s2_d_r[27]}}, s2_d_r};

    s4_np_nxt = s3_sum_r[SW-1] || (s3_sum_r == '0);
    s4_qp_nxt = QPW'(s3_sum_r[DW-1:0]) * QPW'(RECIP);

    quot    = DW'(s4_qp_r >> SHR);
    dac_nxt = s4_np_r ? 16'd0 : ((quot > DAC_LIM) ? 16'(DAC_MAX) : quot[15:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en1)    v1_r    <= take;
      if (en2)    v2_r    <= v1_r;
      if (en3)    v3_r    <= v2_r;
      if (en4)    v4_r    <= v3_r;
      if (en_out) out_v_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_r <= op;
    end
    if (en2) begin
      s2_mode_r <= s1_r.cc_mode;
      s2_ff_r   <= s2_ff_nxt;
      s2_p_r    <= s2_p_nxt;
      s2_i_r    <= s2_i_nxt;
      s2_d_r    <= s2_d_nxt;
    end
    if (en3) begin
      s3_mode_r <= s2_mode_r;
      s3_sum_r  <= s3_sum_nxt;
    end
    if (en4) begin
      s4_mode_r <= s3_mode_r;
      s4_np_r   <= s4_np_nxt;
      s4_qp_r   <= s4_qp_nxt;
    end
    if (en_out) begin
      dac_r      <= dac_nxt;
      mode_out_r <= s4_mode_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, mode_out_r, dac_r};

endmodule

// ----- design/ccpid_state.sv -----
// ccpid_state: configuration registers, loop integrals, previous errors and
// CC/CV mode hysteresis; yields the selected loop operands. Uses ccpid_pkg.
`timescale 1ns / 1ps

module ccpid_state (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ccpid_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [ccpid_pkg::CFG_DW-1:0]      cfg_wdata,
  input  logic                              take,
  input  logic [14:0]                       meas_v,
  input  logic [14:0]                       meas_i,
  input  logic                              out_en,
  output ccpid_pkg::gains_t                 gains,
  output ccpid_pkg::loop_op_t               op
);

  logic [14:0]        tv_r, tc_r, wl_r, oa_r;
  ccpid_pkg::gains_t  gains_r;
  logic signed [15:0] vi_r, ai_r, pve_r, pae_r;
  logic               mode_r;

  logic signed [15:0] ve, ae;
  logic signed [16:0] vd, ad;
  logic signed [15:0] ai_nxt, vi_acc, vi_bled, vi_nxt, wl_s;
  logic               m_set, mode_nxt, over, vi_clr;
  logic [15:0]        v_lim;

  always_comb begin
    ve     = $signed({1'b0, tv_r}) - $signed({1'b0, meas_v});
    ae     = $signed({1'b0, tc_r}) - $signed({1'b0, meas_i});
    vd     = {ve[15], ve} - {pve_r[15], pve_r};
    ad     = {ae[15], ae} - {pae_r[15], pae_r};
    ai_nxt = ccpid_pkg::sat16({ai_r[15], ai_r} + {ae[15], ae});
    vi_acc = out_en ? ccpid_pkg::sat16({vi_r[15], vi_r} + {ve[15], ve}) : '0;

    m_set    = mode_r | (meas_i > tc_r);
    mode_nxt = m_set & ~(ve < ccpid_pkg::MODE_EXIT_ERR);

    v_lim   = {1'b0, tv_r} + {1'b0, oa_r};
    over    = ({1'b0, meas_v} > v_lim) && (vi_acc > ccpid_pkg::BLEED_FLOOR);
    vi_bled = over ? (vi_acc - ccpid_pkg::BLEED_STEP) : vi_acc;

    wl_s = $signed({1'b0, wl_r});
    if (vi_bled > wl_s) begin
      vi_nxt = wl_s;
    end else if (vi_bled < -wl_s) begin
      vi_nxt = -wl_s;
    end else begin
      vi_nxt = vi_bled;
    end

    vi_clr = cfg_we &&
             (((ccpid_pkg::cfg_idx_t'(cfg_addr) == ccpid_pkg::REG_TARGET_V) &&
               (cfg_wdata != tv_r)) ||
              ((ccpid_pkg::cfg_idx_t'(cfg_addr) == ccpid_pkg::REG_TARGET_I) &&
               (cfg_wdata != tc_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r                <= ccpid_pkg::TV_RST;
      tc_r                <= ccpid_pkg::TC_RST;
      gains_r.offset_gain <= ccpid_pkg::OFF_RST;
      gains_r.prop_gain   <= ccpid_pkg::KP_RST;
      gains_r.integ_gain  <= ccpid_pkg::KI_RST;
      gains_r.deriv_gain  <= ccpid_pkg::KD_RST;
      wl_r                <= ccpid_pkg::WL_RST;
      oa_r                <= ccpid_pkg::OA_RST;
    end else if (cfg_we) begin
      unique case (ccpid_pkg::cfg_idx_t'(cfg_addr))
        ccpid_pkg::REG_TARGET_V:  tv_r <= cfg_wdata;
        ccpid_pkg::REG_TARGET_I:  tc_r <= cfg_wdata;
        ccpid_pkg::REG_OFFSET_G:  gains_r.offset_gain <= cfg_wdata[7:0];
        ccpid_pkg::REG_PROP_G:    gains_r.prop_gain   <= cfg_wdata[9:0];
        ccpid_pkg::REG_INTEG_G:   gains_r.integ_gain  <= cfg_wdata[9:0];
        ccpid_pkg::REG_DERIV_G:   gains_r.deriv_gain  <= cfg_wdata[9:0];
        ccpid_pkg::REG_WINDUP:    wl_r <= cfg_wdata;
        ccpid_pkg::REG_OVERSHOOT: oa_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vi_r   <= '0;
      ai_r   <= '0;
      pve_r  <= '0;
      pae_r  <= '0;
      mode_r <= 1'b0;
    end else begin
      if (take) begin
        vi_r   <= vi_nxt;
        ai_r   <= ai_nxt;
        pve_r  <= ve;
        pae_r  <= ae;
        mode_r <= mode_nxt;
      end
      if (vi_clr) begin
        vi_r <= '0;
      end
    end
  end

  assign gains = gains_r;

  always_comb begin
    op.cc_mode  = mode_nxt;
    op.target_v = tv_r;
    op.err      = mode_nxt ? ae : ve;
    op.integ    = mode_nxt ? ai_nxt : vi_bled;
    op.diff     = mode_nxt ? ad : vd;
  end

endmodule
